/* hw/rtl/nsd_pkg.sv */
// Shared constants, codes and helpers for the NMEA sentence deframer.
`default_nettype none
package nsd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 8;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned PHASE_W     = 2;
   localparam int unsigned NIBBLE_W    = 4;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned RSP_DATA_W  = 24;

   localparam int unsigned MAX_PAYLOAD_DEFAULT = 128;

   // Register reset values
   localparam logic [BYTE_W-1:0] START_CHAR_RESET = 8'h24;  // '$'
   localparam logic [BYTE_W-1:0] CHECK_CHAR_RESET = 8'h2A;  // '*'

   // Register indexes (byte address bit 2)
   localparam logic REG_START_CHAR = 1'b0;
   localparam logic REG_CHECK_CHAR = 1'b1;

   // Phase codes
   localparam logic [PHASE_W-1:0] PH_HUNT = 2'd0;
   localparam logic [PHASE_W-1:0] PH_DATA = 2'd1;
   localparam logic [PHASE_W-1:0] PH_HIGH = 2'd2;
   localparam logic [PHASE_W-1:0] PH_LOW  = 2'd3;

   // Sentence status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADHEX   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

   typedef struct packed {
      logic                 ok;
      logic [NIBBLE_W-1:0]  value;
   } hex_digit_type;

   // Upper-case ASCII hex digit decode; invalid digits decode to zero.
   function automatic hex_digit_type hex_decode(input logic [BYTE_W-1:0] c);
      hex_digit_type d;
      d.ok    = 1'b0;
      d.value = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.ok    = 1'b1;
         d.value = c[NIBBLE_W-1:0];
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.ok    = 1'b1;
         d.value = c[NIBBLE_W-1:0] + 4'd9;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/nmea_sentence_deframer_core.sv */
// Top level of the NMEA sentence deframer: byte stream in, payload/status words out.
`default_nettype none
// Takes one received serial byte per word on the req_ stream, hunts for the start
// character, forwards every payload byte (rsp_tuser high) while XORing it into a running
// checksum, then reads the two upper-case hex digits after the check character and closes
// the sentence with one status word (rsp_tlast high): ok, mismatch, bad hex digit, or
// payload overflow. Hunting bytes, the check character and the first checksum digit make
// no output word. Throughput is one byte per clock unless rsp_tready stalls the output; an
// accepted byte passes the input register, then the result register. Start and check
// characters are set over the csr_ port at byte addresses 0 and 4 and apply from the next
// byte; write them only while the stream is idle.
module nmea_sentence_deframer_core #(
   parameter int unsigned MAX_PAYLOAD = nsd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // byte stream in
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [nsd_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] rx_byte
   // result stream out
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [nsd_pkg::RSP_DATA_W-1:0]         rsp_tdata,   // [7:0] payload_byte,
                                                               // [9:8] sentence_status,
                                                               // [17:10] sentence_length,
                                                               // [23:18] zero
   output logic                                   rsp_tuser,   // payload_valid
   output logic                                   rsp_tlast,   // sentence_done
   // configuration
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [nsd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [nsd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [nsd_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);

   localparam logic [nsd_pkg::LEN_W-1:0] MaxLen = nsd_pkg::LEN_W'(MAX_PAYLOAD);

   // ---------------- configuration registers ----------------
   logic [nsd_pkg::BYTE_W-1:0] start_char_ff, start_char_in;
   logic [nsd_pkg::BYTE_W-1:0] check_char_ff, check_char_in;
   logic                       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      start_char_in = start_char_ff;
      check_char_in = check_char_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            nsd_pkg::REG_START_CHAR: start_char_in = csr_pwdata[nsd_pkg::BYTE_W-1:0];
            nsd_pkg::REG_CHECK_CHAR: check_char_in = csr_pwdata[nsd_pkg::BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         unique case (csr_paddr[2])
            nsd_pkg::REG_START_CHAR:
               csr_prdata = nsd_pkg::CSR_DATA_W'(start_char_ff);
            nsd_pkg::REG_CHECK_CHAR:
               csr_prdata = nsd_pkg::CSR_DATA_W'(check_char_ff);
            default: csr_prdata = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_char_ff <= nsd_pkg::START_CHAR_RESET;
         check_char_ff <= nsd_pkg::CHECK_CHAR_RESET;
      end else begin
         start_char_ff <= start_char_in;
         check_char_ff <= check_char_in;
      end
   end

   // ---------------- input register ----------------
   logic                       in_valid_ff, in_valid_in;
   logic [nsd_pkg::BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic                       advance;      // input stage word moves on this cycle

   assign advance    = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   // ---------------- sentence state ----------------
   logic [nsd_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [nsd_pkg::BYTE_W-1:0]   xor_ff, xor_in;
   logic [nsd_pkg::LEN_W-1:0]    count_ff, count_in;
   logic [nsd_pkg::NIBBLE_W-1:0] high_nibble_ff, high_nibble_in;
   logic                         digit_error_ff, digit_error_in;

   // result produced by the current input word
   logic                          res_valid;
   logic                          res_payload;
   logic [nsd_pkg::BYTE_W-1:0]    res_byte;
   logic                          res_done;
   logic [nsd_pkg::STATUS_W-1:0]  res_status;
   logic [nsd_pkg::LEN_W-1:0]     res_length;

   nsd_pkg::hex_digit_type digit;
   logic [nsd_pkg::LEN_W-1:0] count_inc;

   assign digit     = nsd_pkg::hex_decode(in_byte_ff);
   assign count_inc = count_ff + 1'b1;

   always_comb begin
      phase_in       = phase_ff;
      xor_in         = xor_ff;
      count_in       = count_ff;
      high_nibble_in = high_nibble_ff;
      digit_error_in = digit_error_ff;
      res_valid      = 1'b0;
      res_payload    = 1'b0;
      res_byte       = '0;
      res_done       = 1'b0;
      res_status     = nsd_pkg::ST_OK;
      res_length     = count_ff;
      if (advance) begin
         unique case (phase_ff)
            nsd_pkg::PH_HUNT: begin
               if (in_byte_ff == start_char_ff) begin
                  phase_in       = nsd_pkg::PH_DATA;
                  xor_in         = '0;
                  count_in       = '0;
                  high_nibble_in = '0;
                  digit_error_in = 1'b0;
               end
            end
            nsd_pkg::PH_DATA: begin
               // check char wins when it equals the start char
               if (in_byte_ff == check_char_ff) begin
                  phase_in = nsd_pkg::PH_HIGH;
               end else if (count_ff >= MaxLen) begin
                  phase_in   = nsd_pkg::PH_HUNT;
                  res_valid  = 1'b1;
                  res_done   = 1'b1;
                  res_status = nsd_pkg::ST_OVERFLOW;
               end else begin
                  count_in    = count_inc;
                  xor_in      = xor_ff ^ in_byte_ff;
                  res_valid   = 1'b1;
                  res_payload = 1'b1;
                  res_byte    = in_byte_ff;
                  res_length  = count_inc;
               end
            end
            nsd_pkg::PH_HIGH: begin
               high_nibble_in = digit.value;
               digit_error_in = !digit.ok;
               phase_in       = nsd_pkg::PH_LOW;
            end
            nsd_pkg::PH_LOW: begin
               phase_in  = nsd_pkg::PH_HUNT;
               res_valid = 1'b1;
               res_done  = 1'b1;
               if (!digit.ok || digit_error_ff) begin
                  res_status = nsd_pkg::ST_BADHEX;
               end else if ({high_nibble_ff, digit.value} != xor_ff) begin
                  res_status = nsd_pkg::ST_MISMATCH;
               end else begin
                  res_status = nsd_pkg::ST_OK;
               end
            end
            default: phase_in = nsd_pkg::PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= nsd_pkg::PH_HUNT;
         xor_ff         <= '0;
         count_ff       <= '0;
         high_nibble_ff <= '0;
         digit_error_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         xor_ff         <= xor_in;
         count_ff       <= count_in;
         high_nibble_ff <= high_nibble_in;
         digit_error_ff <= digit_error_in;
      end
   end

   // ---------------- result register ----------------
   logic                          out_valid_ff, out_valid_in;
   logic                          out_payload_ff, out_payload_in;
   logic                          out_done_ff, out_done_in;
   logic [nsd_pkg::BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic [nsd_pkg::STATUS_W-1:0]  out_status_ff, out_status_in;
   logic [nsd_pkg::LEN_W-1:0]     out_length_ff, out_length_in;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_payload_in = out_payload_ff;
      out_done_in    = out_done_ff;
      out_byte_in    = out_byte_ff;
      out_status_in  = out_status_ff;
      out_length_in  = out_length_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (res_valid) begin
         out_valid_in   = 1'b1;
         out_payload_in = res_payload;
         out_done_in    = res_done;
         out_byte_in    = res_byte;
         out_status_in  = res_status;
         out_length_in  = res_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_payload_ff <= out_payload_in;
      out_done_ff    <= out_done_in;
      out_byte_ff    <= out_byte_in;
      out_status_ff  <= out_status_in;
      out_length_ff  <= out_length_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_payload_ff;
   assign rsp_tlast  = out_done_ff;
   assign rsp_tdata  = nsd_pkg::RSP_DATA_W'({out_length_ff, out_status_ff, out_byte_ff});

   // ---------------- assertions ----------------
   // payload words never close a sentence and carry status ok
   a_payload_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (!rsp_tlast && rsp_tdata[9:8] == nsd_pkg::ST_OK))
      else $error("payload word with close flag or nonzero status");

   // every output word is either payload or a sentence close
   a_word_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("output word is neither payload nor close");

   // reported length stays within the payload limit
   a_length_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[17:10] <= MaxLen))
      else $error("sentence length beyond limit");

   // a result is only produced from a word that left the input stage
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(in_valid_ff))
      else $error("result appeared without an input word");

endmodule
`default_nettype wire

/* tb/sv/tb_nmea_sentence_deframer_core.sv */
// Self-checking testbench for the NMEA sentence deframer core.
`default_nettype none

// One word on the result stream, as the block should produce it.
typedef struct packed {
   logic                         payload_valid;
   logic [nsd_pkg::BYTE_W-1:0]   payload_byte;
   logic                         sentence_done;
   logic [nsd_pkg::STATUS_W-1:0] sentence_status;
   logic [nsd_pkg::LEN_W-1:0]    sentence_length;
} sentence_word_type;

// Tracks the deframer state byte by byte and queues the words it must emit.
class sentence_tracker;
   logic [nsd_pkg::BYTE_W-1:0]   start_char;
   logic [nsd_pkg::BYTE_W-1:0]   check_char;
   logic [nsd_pkg::PHASE_W-1:0]  phase;
   logic [nsd_pkg::BYTE_W-1:0]   running_xor;
   logic [nsd_pkg::LEN_W-1:0]    byte_count;
   logic [nsd_pkg::NIBBLE_W-1:0] high_nibble;
   logic                         digit_error;
   sentence_word_type            expected_words[$];
   int                           errors;
   int                           bytes_taken;
   int                           payload_words;
   int                           closed_by_status[4];

   function new();
      start_char  = nsd_pkg::START_CHAR_RESET;
      check_char  = nsd_pkg::CHECK_CHAR_RESET;
      phase       = nsd_pkg::PH_HUNT;
      running_xor = '0;
      byte_count  = '0;
      high_nibble = '0;
      digit_error = 1'b0;
      errors      = 0;
      bytes_taken = 0;
      payload_words = 0;
      foreach (closed_by_status[i]) closed_by_status[i] = 0;
   endfunction

   function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
   endfunction

   function void set_reg(logic idx, logic [nsd_pkg::BYTE_W-1:0] value);
      if (idx == nsd_pkg::REG_START_CHAR) start_char = value;
      else check_char = value;
   endfunction

   // Upper-case ASCII hex only.
   function bit hex_digit(logic [nsd_pkg::BYTE_W-1:0] c,
                          output logic [nsd_pkg::NIBBLE_W-1:0] v);
      v = '0;
      if (c >= "0" && c <= "9") begin
         v = nsd_pkg::NIBBLE_W'(c - "0");
         return 1'b1;
      end
      if (c >= "A" && c <= "F") begin
         v = nsd_pkg::NIBBLE_W'(c - "A" + 10);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function void close_sentence(logic [nsd_pkg::STATUS_W-1:0] status);
      sentence_word_type w;
      w = '0;
      w.sentence_done   = 1'b1;
      w.sentence_status = status;
      w.sentence_length = byte_count;
      expected_words.push_back(w);
   endfunction

   function void note_byte(logic [nsd_pkg::BYTE_W-1:0] b);
      sentence_word_type            w;
      logic [nsd_pkg::NIBBLE_W-1:0] v;
      bit                           ok;
      bytes_taken++;
      case (phase)
         nsd_pkg::PH_HUNT: begin
            if (b == start_char) begin
               phase       = nsd_pkg::PH_DATA;
               running_xor = '0;
               byte_count  = '0;
               high_nibble = '0;
               digit_error = 1'b0;
            end
         end
         nsd_pkg::PH_DATA: begin
            if (b == check_char) begin
               phase = nsd_pkg::PH_HIGH;
            end else if (byte_count >= nsd_pkg::MAX_PAYLOAD_DEFAULT) begin
               phase = nsd_pkg::PH_HUNT;
               close_sentence(nsd_pkg::ST_OVERFLOW);
            end else begin
               byte_count  = byte_count + 1'b1;
               running_xor = running_xor ^ b;
               w = '0;
               w.payload_valid   = 1'b1;
               w.payload_byte    = b;
               w.sentence_length = byte_count;
               expected_words.push_back(w);
            end
         end
         nsd_pkg::PH_HIGH: begin
            ok          = hex_digit(b, v);
            high_nibble = v;
            digit_error = !ok;
            phase       = nsd_pkg::PH_LOW;
         end
         default: begin
            ok    = hex_digit(b, v);
            phase = nsd_pkg::PH_HUNT;
            if (!ok || digit_error) close_sentence(nsd_pkg::ST_BADHEX);
            else if ({high_nibble, v} != running_xor) close_sentence(nsd_pkg::ST_MISMATCH);
            else close_sentence(nsd_pkg::ST_OK);
         end
      endcase
   endfunction

   function void check_word(logic tuser, logic tlast, logic [nsd_pkg::RSP_DATA_W-1:0] tdata);
      sentence_word_type w;
      if (expected_words.size() == 0) begin
         flag($sformatf("unexpected word tuser=%b tlast=%b tdata=%06h", tuser, tlast, tdata));
         return;
      end
      w = expected_words.pop_front();
      if (w.payload_valid) payload_words++;
      else closed_by_status[w.sentence_status]++;
      if (tuser !== w.payload_valid || tlast !== w.sentence_done ||
          tdata[7:0] !== w.payload_byte || tdata[9:8] !== w.sentence_status ||
          tdata[17:10] !== w.sentence_length || tdata[nsd_pkg::RSP_DATA_W-1:18] !== '0)
         flag($sformatf({"word mismatch: exp valid=%b byte=%02h done=%b status=%0d len=%0d",
                         " / got valid=%b byte=%02h done=%b status=%0d len=%0d pad=%02h"},
                        w.payload_valid, w.payload_byte, w.sentence_done,
                        w.sentence_status, w.sentence_length,
                        tuser, tdata[7:0], tlast, tdata[9:8], tdata[17:10],
                        tdata[nsd_pkg::RSP_DATA_W-1:18]));
   endfunction
endclass

module tb_nmea_sentence_deframer_core;

   localparam int PIPE_LATENCY = 2;       // input register + result register
   localparam int CYCLE_LIMIT  = 400000;  // far beyond the slowest legal run
   localparam int DRAIN_LIMIT  = 5000;
   localparam int PHASE_BYTES  = 105;     // sentence bytes per register setting

   typedef enum int {SENT_GOOD, SENT_BAD_SUM, SENT_BAD_HIGH, SENT_BAD_LOW,
                     SENT_BAD_BOTH, SENT_OVERFLOW} sentence_kind_type;

   logic clock;
   logic reset = 1'b1;

   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [nsd_pkg::BYTE_W-1:0]         req_tdata  = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [nsd_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic                               rsp_tuser;
   logic                               rsp_tlast;
   logic                               csr_psel    = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite  = 1'b0;
   logic [nsd_pkg::CSR_ADDR_W-1:0]     csr_paddr   = '0;
   logic [nsd_pkg::CSR_DATA_W-1:0]     csr_pwdata  = '0;
   logic [nsd_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                               csr_pready;

   nmea_sentence_deframer_core #(
      .MAX_PAYLOAD (nsd_pkg::MAX_PAYLOAD_DEFAULT)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sentence_tracker            trk;
   logic [nsd_pkg::BYTE_W-1:0] byte_q[$];     // bytes waiting to go out on the req_ stream
   int                         cycle_count = 0;
   int                         settings_run = 0;

   // Receiver back-pressure: the mode is picked anew whenever stall_left runs out.
   int stall_mode = 0;
   int stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_nmea_sentence_deframer_core: FAIL");
         $finish;
      end
   end

   // rsp_tready: always ready, random, short duty cycle, or long stalls.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 9) < 7);
         2:       rsp_tready <= ((cycle_count % 5) < 2);
         default: rsp_tready <= ((cycle_count % 16) == 0);
      endcase
   end

   // Both handshakes are sampled at the edge, before any update of that edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) trk.note_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) trk.check_word(rsp_tuser, rsp_tlast, rsp_tdata);
      end
   end

   // --- stimulus helpers -------------------------------------------------

   function automatic logic [nsd_pkg::BYTE_W-1:0] hex_char(logic [nsd_pkg::NIBBLE_W-1:0] n);
      return (n < 10) ? nsd_pkg::BYTE_W'("0" + n) : nsd_pkg::BYTE_W'("A" + n - 10);
   endfunction

   // Non-hex bytes, mostly just outside the digit ranges, lower case included.
   function automatic logic [nsd_pkg::BYTE_W-1:0] bad_digit();
      case ($urandom_range(0, 8))
         0:       return 8'h2F;   // '/'
         1:       return 8'h3A;   // ':'
         2:       return 8'h40;   // '@'
         3:       return 8'h47;   // 'G'
         4:       return 8'h61;   // 'a'
         5:       return 8'h66;   // 'f'
         6:       return 8'h00;
         7:       return 8'hFF;
         default: return nsd_pkg::BYTE_W'($urandom_range(8'h80, 8'hFF));
      endcase
   endfunction

   // Body byte that cannot end the payload.
   function automatic logic [nsd_pkg::BYTE_W-1:0] body_byte();
      logic [nsd_pkg::BYTE_W-1:0] b;
      do b = nsd_pkg::BYTE_W'($urandom_range(0, 255)); while (b == trk.check_char);
      return b;
   endfunction

   function automatic void add_sentence(int len, sentence_kind_type kind);
      logic [nsd_pkg::BYTE_W-1:0] sum;
      logic [nsd_pkg::BYTE_W-1:0] b;
      sum = '0;
      byte_q.push_back(trk.start_char);
      for (int i = 0; i < len; i++) begin
         b = body_byte();
         sum ^= b;
         byte_q.push_back(b);
      end
      if (kind == SENT_OVERFLOW) return;   // no check char, block gives up on its own
      byte_q.push_back(trk.check_char);
      if (kind == SENT_BAD_SUM) sum ^= nsd_pkg::BYTE_W'($urandom_range(1, 255));
      byte_q.push_back((kind == SENT_BAD_HIGH || kind == SENT_BAD_BOTH) ?
                       bad_digit() : hex_char(sum[7:4]));
      byte_q.push_back((kind == SENT_BAD_LOW || kind == SENT_BAD_BOTH) ?
                       bad_digit() : hex_char(sum[3:0]));
   endfunction

   // Mostly well-formed sentences of small size; noise between them is not counted.
   function automatic void fill_random(int target);
      int made;
      int len;
      int pick;
      made = 0;
      while (made < target) begin
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         if (pick < 52)      add_sentence(len, SENT_GOOD);
         else if (pick < 66) add_sentence(len, SENT_BAD_SUM);
         else if (pick < 73) add_sentence(len, SENT_BAD_HIGH);
         else if (pick < 80) add_sentence(len, SENT_BAD_LOW);
         else if (pick < 84) add_sentence(len, SENT_BAD_BOTH);
         else if (pick < 85) begin
            len = nsd_pkg::MAX_PAYLOAD_DEFAULT + 1 + $urandom_range(0, 2);
            add_sentence(len, SENT_OVERFLOW);
         end else if (pick < 86) begin
            len = nsd_pkg::MAX_PAYLOAD_DEFAULT;
            add_sentence(len, SENT_GOOD);
         end else begin
            repeat ($urandom_range(1, 5))
               byte_q.push_back(nsd_pkg::BYTE_W'($urandom_range(0, 255)));
            continue;
         end
         made += len + 4;
      end
   endfunction

   // --- bus tasks --------------------------------------------------------

   // Drains byte_q in bursts with random gaps; zero gaps keep tvalid high across words.
   task automatic send_bytes();
      int burst_left;
      int gap;
      burst_left = 0;
      while (byte_q.size() > 0) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_tvalid <= 1'b1;
         req_tdata  <= byte_q.pop_front();
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         burst_left--;
      end
      req_tvalid <= 1'b0;
   endtask

   // Upper pwdata bits are junk; the registers are 8 bits wide.
   task automatic csr_write(logic idx, logic [nsd_pkg::BYTE_W-1:0] value);
      logic [nsd_pkg::CSR_DATA_W-1:0] wdata;
      wdata      = $urandom;
      wdata[7:0] = value;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);            // write lands here
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      trk.set_reg(idx, value);
   endtask

   task automatic csr_read_check(logic idx, logic [nsd_pkg::BYTE_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);            // read completes; prdata sampled at this edge
      if (csr_prdata[7:0] !== value)
         trk.flag($sformatf("register %0d readback exp %02h got %02h",
                            idx, value, csr_prdata[7:0]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_chars(logic [nsd_pkg::BYTE_W-1:0] start_c,
                            logic [nsd_pkg::BYTE_W-1:0] check_c);
      csr_write(nsd_pkg::REG_START_CHAR, start_c);
      csr_write(nsd_pkg::REG_CHECK_CHAR, check_c);
      csr_read_check(nsd_pkg::REG_START_CHAR, start_c);
      csr_read_check(nsd_pkg::REG_CHECK_CHAR, check_c);
      settings_run++;
   endtask

   // Wait for every expected word, then let bytes that make no word clear the pipe.
   task automatic settle();
      int waited;
      waited = 0;
      while (trk.expected_words.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (trk.expected_words.size() > 0) begin
         trk.flag($sformatf("%0d expected words never arrived", trk.expected_words.size()));
         trk.expected_words.delete();
      end
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // --- test sequence ----------------------------------------------------

   logic [nsd_pkg::BYTE_W-1:0] start_list[7];
   logic [nsd_pkg::BYTE_W-1:0] check_list[7];

   initial begin
      trk = new();
      // reset values, zero and all-ones, swapped, equal chars, random,
      // chars that are also hex digits, and back to reset values
      start_list = '{8'h24, 8'h00, 8'hFF, 8'h55, 8'h00, 8'h41, nsd_pkg::START_CHAR_RESET};
      check_list = '{8'h2A, 8'hFF, 8'h00, 8'h55, 8'h00, 8'h30, nsd_pkg::CHECK_CHAR_RESET};
      start_list[4] = nsd_pkg::BYTE_W'($urandom_range(0, 255));
      check_list[4] = nsd_pkg::BYTE_W'($urandom_range(0, 255));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed bytes with the reset-time characters.
      byte_q = '{8'h00, 8'hFF,                       // ignored while hunting
                 "$", "A", "*", "4", "1",            // good sentence
                 "$", "*", "0", "0",                 // empty payload
                 "$", 8'hFF, "*", "F", "0",          // checksum mismatch
                 "$", "Z", "*", "g", "0",            // lower-case high digit
                 "$", "$", "*", "0", ":"};           // start char as payload, bad low digit
      send_bytes();
      settle();

      foreach (start_list[p]) begin
         set_chars(start_list[p], check_list[p]);
         if (p == 0) add_sentence(nsd_pkg::MAX_PAYLOAD_DEFAULT + 1, SENT_OVERFLOW);
         if (p == 6) add_sentence(nsd_pkg::MAX_PAYLOAD_DEFAULT, SENT_GOOD);
         fill_random(PHASE_BYTES);
         // sometimes leave a sentence open so the next setting lands mid-sentence
         if ($urandom_range(0, 1) == 1) begin
            byte_q.push_back(trk.start_char);
            repeat ($urandom_range(0, 3)) byte_q.push_back(body_byte());
         end
         send_bytes();
         settle();
      end

      $display("covered %0d bytes under %0d character settings: %0d payload words",
               trk.bytes_taken, settings_run, trk.payload_words);
      $display("sentences closed ok/mismatch/bad-hex/overflow: %0d/%0d/%0d/%0d, errors %0d",
               trk.closed_by_status[nsd_pkg::ST_OK],
               trk.closed_by_status[nsd_pkg::ST_MISMATCH],
               trk.closed_by_status[nsd_pkg::ST_BADHEX],
               trk.closed_by_status[nsd_pkg::ST_OVERFLOW],
               trk.errors);
      if (trk.errors == 0) begin
         $display("tb_nmea_sentence_deframer_core: PASS");
      end else begin
         $display("tb_nmea_sentence_deframer_core: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/nsd_pkg.sv
hw/rtl/nmea_sentence_deframer_core.sv
tb/sv/tb_nmea_sentence_deframer_core.sv
